FILE: hw/rtl/mvwft_pkg.sv
// ----------------------------------------------------------------------------
// Mesh vertex weld package
// Shared constants, the sequencer state type and small helpers for the mesh
// vertex weld and fan triangulation block.
// ----------------------------------------------------------------------------
package mvwft_pkg;

  // Default store sizes.
  localparam int unsigned MAX_POSITIONS_DEF = 65536;
  localparam int unsigned MAX_VERTICES_DEF  = 65536;

  // Width of the run epoch kept beside each bucket head.
  localparam int unsigned EPOCH_W = 4;

  // Width of one corner index field and of the configuration register.
  localparam int unsigned INDEX_W  = 32;
  localparam int unsigned PCOUNT_W = 17;

  // Register word index of position_count.
  localparam logic REG_POSITION_COUNT = 1'b0;

  // Corner selectors within one triangle.
  localparam logic [1:0] SEL_FIRST = 2'd0;
  localparam logic [1:0] SEL_PREV  = 2'd1;
  localparam logic [1:0] SEL_CUR   = 2'd2;

  // Corner-in-face codes.
  localparam logic [1:0] CIF_NONE   = 2'd0;
  localparam logic [1:0] CIF_FIRST  = 2'd1;
  localparam logic [1:0] CIF_SECOND = 2'd2;
  localparam logic [1:0] CIF_FAN    = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_HEAD,
    ST_HWAIT,
    ST_CHAIN,
    ST_ALLOC,
    ST_EMIT
  } seq_state_t;

  // A position index is usable when it lies below both limits.
  function automatic logic pos_ok(input logic [INDEX_W-1:0] p,
                                  input logic [PCOUNT_W-1:0] pc,
                                  input logic [INDEX_W-1:0] lim);
    return (p < INDEX_W'(pc)) && (p < lim);
  endfunction

endpackage

FILE: hw/rtl/mesh_vertex_weld_fan_triangulate.sv
// ----------------------------------------------------------------------------
// Mesh vertex weld and fan triangulation
// Fan-triangulates polygon corners and welds each triangle corner to a
// unique vertex index through a position-bucketed hash chain.
// ----------------------------------------------------------------------------
// Usage:
// Corners arrive on the s_ stream, one word each. From the third corner of a
// face on, each corner yields one triangle when the first, previous and
// current positions are usable: three words on the m_ stream in the order
// first, previous, current corner, with m_tlast on the third.
// position_count is written over the APB port while the block is idle; the
// user is bound to this, and the block itself does not enforce it.
// Each triangle corner costs a bucket head read, a vertex read per chain
// entry visited, an allocation step when no match is found, and a step to
// hand the word to the output register.
// After reset the block sweeps the bucket memory, one entry a cycle, through
// all MAX_POSITIONS entries before s_tready rises. Run starts are handled by
// an epoch mark; every sixteenth run start repeats that sweep. When the
// receiver stalls, the finished word waits in the output register and the
// sequencer holds until it is taken.
// ----------------------------------------------------------------------------
module mesh_vertex_weld_fan_triangulate #(
  parameter int unsigned MAX_POSITIONS = mvwft_pkg::MAX_POSITIONS_DEF,
  parameter int unsigned MAX_VERTICES  = mvwft_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Corner stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // position_index, texcoord_index, normal_index
  input  logic [1:0]  s_tuser,   // run_start, face_start
  // Vertex stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // vertex_index, source_position,
                                 // source_texcoord, source_normal
  output logic [3:0]  m_tuser,   // is_new, uv_seen, normal_seen, overflow
  output logic        m_tlast,   // triangle_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW  = $clog2(MAX_POSITIONS);
  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned EW  = mvwft_pkg::EPOCH_W;
  localparam int unsigned IW  = mvwft_pkg::INDEX_W;
  localparam int unsigned BW  = EW + VW + 1;
  localparam int unsigned VDW = VW + 1 + 2 * IW;

  mvwft_pkg::seq_state_t state, state_next;

  // Control registers.
  logic [mvwft_pkg::PCOUNT_W-1:0] position_count;
  logic [EW-1:0]                  epoch;
  logic [VW:0]                    vertex_count;
  logic [1:0]                     corner_in_face;
  logic                           first_valid;
  logic                           uv_flag;
  logic                           normal_flag;
  logic [PW-1:0]                  clr_addr;
  logic                           clr_resume;
  logic [1:0]                     wsel;
  logic                           out_valid;

  // Payload registers.
  logic [IW-1:0] cur_pos, cur_tc, cur_nm;
  logic          cur_face;
  logic [IW-1:0] first_pos, first_tc, first_nm;
  logic [IW-1:0] prev_pos, prev_tc, prev_nm;
  logic [VW:0]   head_link;
  logic [VW-1:0] cand;
  logic [VW-1:0] res_v;
  logic          res_new;
  logic          res_ovf;
  logic [95:0]   out_data;
  logic [3:0]    out_user;
  logic          out_last;

  // Sequencer strobes.
  logic          do_accept;
  logic          do_face;
  logic          do_second;
  logic          do_fan;
  logic          do_advance;
  logic          do_found;
  logic          do_alloc;
  logic          do_full;
  logic          do_emit;
  logic          ld_cand;
  logic [VW-1:0] cand_next;

  // Memory ports.
  logic          b_wen, b_ren;
  logic [PW-1:0] b_waddr;
  logic [BW-1:0] b_wdata, b_rdata;
  logic          v_wen, v_ren;
  logic [VW-1:0] v_raddr;
  logic [VDW-1:0] v_wdata, v_rdata;

  // Selected triangle corner and lookup helpers.
  logic [IW-1:0] sel_pos, sel_tc, sel_nm;
  logic [VW:0]   head_eff;
  logic [VW:0]   chain_link;
  logic [2*IW-1:0] chain_key;
  logic          store_full;
  logic          tri_ok;
  logic          cfg_wr;
  logic [31:0]   res_v32;
  logic [EW-1:0] epoch_inc;

  always_comb begin
    unique case (wsel)
      mvwft_pkg::SEL_FIRST: begin
        sel_pos = first_pos; sel_tc = first_tc; sel_nm = first_nm;
      end
      mvwft_pkg::SEL_PREV: begin
        sel_pos = prev_pos; sel_tc = prev_tc; sel_nm = prev_nm;
      end
      default: begin
        sel_pos = cur_pos; sel_tc = cur_tc; sel_nm = cur_nm;
      end
    endcase
  end

  // A bucket head from an earlier run reads as empty.
  assign head_eff   = (b_rdata[BW-1 -: EW] == epoch) ? b_rdata[VW:0] : '0;
  assign chain_link = v_rdata[VDW-1 -: (VW + 1)];
  assign chain_key  = v_rdata[2*IW-1:0];
  assign store_full = vertex_count >= (VW + 1)'(MAX_VERTICES);
  assign epoch_inc  = epoch + EW'(1);
  assign tri_ok     = first_valid &&
                      mvwft_pkg::pos_ok(prev_pos, position_count, IW'(MAX_POSITIONS)) &&
                      mvwft_pkg::pos_ok(cur_pos, position_count, IW'(MAX_POSITIONS));

  // Next state and strobes.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    do_accept  = 1'b0;
    do_face    = 1'b0;
    do_second  = 1'b0;
    do_fan     = 1'b0;
    do_advance = 1'b0;
    do_found   = 1'b0;
    do_alloc   = 1'b0;
    do_full    = 1'b0;
    do_emit    = 1'b0;
    ld_cand    = 1'b0;
    cand_next  = '0;
    b_ren      = 1'b0;
    v_ren      = 1'b0;
    v_raddr    = '0;
    unique case (state)
      mvwft_pkg::ST_CLEAR: begin
        if (clr_addr == PW'(MAX_POSITIONS - 1)) begin
          state_next = clr_resume ? mvwft_pkg::ST_DECIDE : mvwft_pkg::ST_IDLE;
        end
      end
      mvwft_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          do_accept = 1'b1;
          if (s_tuser[0] && (epoch_inc == '0)) begin
            state_next = mvwft_pkg::ST_CLEAR;
          end else begin
            state_next = mvwft_pkg::ST_DECIDE;
          end
        end
      end
      mvwft_pkg::ST_DECIDE: begin
        state_next = mvwft_pkg::ST_IDLE;
        if (cur_face) begin
          do_face = 1'b1;
        end else if (corner_in_face == mvwft_pkg::CIF_FIRST) begin
          do_second = 1'b1;
        end else if (corner_in_face != mvwft_pkg::CIF_NONE) begin
          do_fan = 1'b1;
          if (tri_ok) begin
            state_next = mvwft_pkg::ST_HEAD;
          end else begin
            do_advance = 1'b1;
          end
        end
      end
      mvwft_pkg::ST_HEAD: begin
        b_ren      = 1'b1;
        state_next = mvwft_pkg::ST_HWAIT;
      end
      mvwft_pkg::ST_HWAIT: begin
        if (head_eff != '0) begin
          cand_next  = VW'(head_eff - (VW + 1)'(1));
          ld_cand    = 1'b1;
          v_ren      = 1'b1;
          v_raddr    = cand_next;
          state_next = mvwft_pkg::ST_CHAIN;
        end else begin
          state_next = mvwft_pkg::ST_ALLOC;
        end
      end
      mvwft_pkg::ST_CHAIN: begin
        if (chain_key == {sel_tc, sel_nm}) begin
          do_found   = 1'b1;
          state_next = mvwft_pkg::ST_EMIT;
        end else if (chain_link != '0) begin
          cand_next = VW'(chain_link - (VW + 1)'(1));
          ld_cand   = 1'b1;
          v_ren     = 1'b1;
          v_raddr   = cand_next;
        end else begin
          state_next = mvwft_pkg::ST_ALLOC;
        end
      end
      mvwft_pkg::ST_ALLOC: begin
        if (store_full) begin
          do_full = 1'b1;
        end else begin
          do_alloc = 1'b1;
        end
        state_next = mvwft_pkg::ST_EMIT;
      end
      mvwft_pkg::ST_EMIT: begin
        if (!out_valid || m_tready) begin
          do_emit = 1'b1;
          if (wsel == mvwft_pkg::SEL_CUR) begin
            do_advance = 1'b1;
            state_next = mvwft_pkg::ST_IDLE;
          end else begin
            state_next = mvwft_pkg::ST_HEAD;
          end
        end
      end
      default: state_next = mvwft_pkg::ST_IDLE;
    endcase
  end

  // Bucket memory write: sweep or allocation.
  always_comb begin
    b_wen   = 1'b0;
    b_waddr = sel_pos[PW-1:0];
    b_wdata = {epoch, vertex_count + (VW + 1)'(1)};
    if (state == mvwft_pkg::ST_CLEAR) begin
      b_wen   = 1'b1;
      b_waddr = clr_addr;
      b_wdata = '0;
    end else if (do_alloc) begin
      b_wen = 1'b1;
    end
  end

  assign v_wen   = do_alloc;
  assign v_wdata = {head_link, sel_tc, sel_nm};

  mvwft_bucket_mem #(
    .DEPTH (MAX_POSITIONS),
    .AW    (PW),
    .DW    (BW)
  ) u_bucket (
    .clk   (clk),
    .wen   (b_wen),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .ren   (b_ren),
    .raddr (sel_pos[PW-1:0]),
    .rdata (b_rdata)
  );

  mvwft_vertex_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .DW    (VDW)
  ) u_vertex (
    .clk   (clk),
    .wen   (v_wen),
    .waddr (vertex_count[VW-1:0]),
    .wdata (v_wdata),
    .ren   (v_ren),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // State register and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mvwft_pkg::ST_CLEAR;
      epoch          <= '0;
      vertex_count   <= '0;
      corner_in_face <= mvwft_pkg::CIF_NONE;
      first_valid    <= 1'b0;
      uv_flag        <= 1'b0;
      normal_flag    <= 1'b0;
      clr_addr       <= '0;
      clr_resume     <= 1'b0;
      wsel           <= mvwft_pkg::SEL_FIRST;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mvwft_pkg::ST_CLEAR) begin
        if (clr_addr == PW'(MAX_POSITIONS - 1)) begin
          clr_addr <= '0;
        end else begin
          clr_addr <= clr_addr + PW'(1);
        end
      end
      if (do_accept && s_tuser[0]) begin
        epoch          <= epoch_inc;
        vertex_count   <= '0;
        uv_flag        <= 1'b0;
        normal_flag    <= 1'b0;
        corner_in_face <= mvwft_pkg::CIF_NONE;
        first_valid    <= 1'b0;
        clr_resume     <= 1'b1;
      end
      if (do_face) begin
        corner_in_face <= mvwft_pkg::CIF_FIRST;
        first_valid    <= mvwft_pkg::pos_ok(cur_pos, position_count, IW'(MAX_POSITIONS));
      end
      if (do_second) begin
        corner_in_face <= mvwft_pkg::CIF_SECOND;
      end
      if (do_fan) begin
        corner_in_face <= mvwft_pkg::CIF_FAN;
        wsel           <= mvwft_pkg::SEL_FIRST;
      end
      if (do_alloc) begin
        vertex_count <= vertex_count + (VW + 1)'(1);
        if (!sel_tc[IW-1]) begin
          uv_flag <= 1'b1;
        end
        if (!sel_nm[IW-1]) begin
          normal_flag <= 1'b1;
        end
      end
      if (do_emit && (wsel != mvwft_pkg::SEL_CUR)) begin
        wsel <= wsel + 2'd1;
      end
      if (do_emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration register.
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
    end else if (cfg_wr && (paddr[2] == mvwft_pkg::REG_POSITION_COUNT)) begin
      position_count <= pwdata[mvwft_pkg::PCOUNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mvwft_pkg::REG_POSITION_COUNT) ?
                  32'(position_count) : 32'd0;

  // Corner payload and lookup results.
  always_ff @(posedge clk) begin
    if (do_accept) begin
      cur_pos  <= s_tdata[IW-1:0];
      cur_tc   <= s_tdata[2*IW-1:IW];
      cur_nm   <= s_tdata[3*IW-1:2*IW];
      cur_face <= s_tuser[1];
    end
    if (do_face) begin
      first_pos <= cur_pos;
      first_tc  <= cur_tc;
      first_nm  <= cur_nm;
    end
    if (do_second || do_advance) begin
      prev_pos <= cur_pos;
      prev_tc  <= cur_tc;
      prev_nm  <= cur_nm;
    end
    if (state == mvwft_pkg::ST_HWAIT) begin
      head_link <= head_eff;
    end
    if (ld_cand) begin
      cand <= cand_next;
    end
    if (do_found) begin
      res_v   <= cand;
      res_new <= 1'b0;
      res_ovf <= 1'b0;
    end
    if (do_alloc) begin
      res_v   <= vertex_count[VW-1:0];
      res_new <= 1'b1;
      res_ovf <= 1'b0;
    end
    if (do_full) begin
      res_v   <= '0;
      res_new <= 1'b0;
      res_ovf <= 1'b1;
    end
  end

  // Output register.
  assign res_v32 = 32'(res_v);

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_data <= {sel_nm, sel_tc, sel_pos[15:0], res_v32[15:0]};
      out_user <= {res_ovf, normal_flag, uv_flag, res_new};
      out_last <= (wsel == mvwft_pkg::SEL_CUR);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

endmodule

FILE: hw/rtl/mvwft_bucket_mem.sv
// ----------------------------------------------------------------------------
// Bucket head memory
// One entry per source position: the run epoch and the link (vertex + 1) of
// the newest vertex of that bucket. One write port, one registered read.
// ----------------------------------------------------------------------------
module mvwft_bucket_mem #(
  parameter int unsigned DEPTH = mvwft_pkg::MAX_POSITIONS_DEF,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 21
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          ren,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mvwft_vertex_mem.sv
// ----------------------------------------------------------------------------
// Vertex memory
// One entry per allocated vertex: the chain link to the next older vertex of
// the same bucket and the texcoord/normal key. One write, one registered read.
// ----------------------------------------------------------------------------
module mvwft_vertex_mem #(
  parameter int unsigned DEPTH = mvwft_pkg::MAX_VERTICES_DEF,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 81
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          ren,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: test/tb_mesh_vertex_weld_fan_triangulate.sv
// ----------------------------------------------------------------------------
// Mesh vertex weld testbench
// Streams polygon corners into the block and checks every vertex word against
// a behavioural weld and fan model. A directed table covers the short-face,
// invalid-corner and run-start cases. Random faces follow under several
// position_count settings and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_weld_fan_triangulate;

  localparam int unsigned POS_LIMIT = 65536;
  localparam int unsigned VTX_LIMIT = 65536;
  localparam int unsigned SETTLE    = 60;

  // One vertex word as the block presents it.
  typedef struct packed {
    logic [15:0] vertex_index;
    logic        is_new;
    logic [15:0] source_position;
    logic [31:0] source_texcoord;
    logic [31:0] source_normal;
    logic        uv_seen;
    logic        normal_seen;
    logic        triangle_last;
    logic        overflow;
  } vertex_word_t;

  // One corner: position, texcoord, normal.
  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] tex;
    logic [31:0] nrm;
  } corner_t;

  // Directed row: flags, corner, and where obvious the word count and the
  // index and new mark of the last corner (count -1 leaves it to the model).
  typedef struct packed {
    logic        run;
    logic        face;
    corner_t     c;
    int          n_words;
    logic [15:0] last_index;
    logic        last_new;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mesh_vertex_weld_fan_triangulate dut (.*);

  always #10 clk = ~clk;

  // Model state of the weld table and the fan.
  int unsigned       bucket_head [int unsigned];
  int unsigned       chain_next  [int unsigned];
  logic [63:0]       vertex_key  [int unsigned];
  logic [15:0]       vertex_pos  [int unsigned];
  int unsigned       vertex_count;
  corner_t           fan_first, fan_prev;
  logic [1:0]        face_phase;
  logic              first_ok, uv_flag, normal_flag;
  logic [16:0]       pos_count;
  vertex_word_t      pending_words[$];
  int                errors = 0;
  int                sender_idle_pct = 0, receiver_stall_pct = 0;

  function automatic logic pos_usable(logic [31:0] p);
    return (p < 32'(pos_count)) && (p < POS_LIMIT);
  endfunction

  // Looks up or allocates the vertex for one triangle corner.
  function automatic vertex_word_t weld_corner(corner_t c, logic last);
    vertex_word_t w;
    logic [63:0]  key;
    int unsigned  link, v;
    bit           found, ovf;
    key = {c.tex, c.nrm};
    link = bucket_head.exists(c.pos) ? bucket_head[c.pos] : 0;
    found = 0;
    ovf = 0;
    v = 0;
    w = '0;
    while (link != 0 && link <= VTX_LIMIT && !found) begin
      if (vertex_key[link-1] == key) begin
        v = link - 1;
        found = 1;
      end else begin
        link = chain_next[link-1];
      end
    end
    if (!found) begin
      if (vertex_count >= VTX_LIMIT) begin
        ovf = 1;
      end else begin
        v = vertex_count++;
        chain_next[v] = bucket_head.exists(c.pos) ? bucket_head[c.pos] : 0;
        bucket_head[c.pos] = v + 1;
        vertex_key[v] = key;
        vertex_pos[v] = c.pos[15:0];
        w.is_new = 1'b1;
        if (!c.tex[31]) uv_flag = 1'b1;
        if (!c.nrm[31]) normal_flag = 1'b1;
      end
    end
    if (ovf) begin
      w.source_position = c.pos[15:0];
      w.source_texcoord = c.tex;
      w.source_normal = c.nrm;
    end else begin
      w.vertex_index = v[15:0];
      w.source_position = vertex_pos[v];
      w.source_texcoord = vertex_key[v][63:32];
      w.source_normal = vertex_key[v][31:0];
    end
    w.uv_seen = uv_flag;
    w.normal_seen = normal_flag;
    w.triangle_last = last;
    w.overflow = ovf;
    return w;
  endfunction

  // Advances the fan by one accepted corner and queues the words it yields.
  function automatic int fan_corner(logic run, logic face, corner_t c);
    if (run) begin
      bucket_head.delete();
      vertex_count = 0;
      uv_flag = 1'b0;
      normal_flag = 1'b0;
      face_phase = mvwft_pkg::CIF_NONE;
      first_ok = 1'b0;
    end
    if (face) begin
      fan_first = c;
      first_ok = pos_usable(c.pos);
      face_phase = mvwft_pkg::CIF_FIRST;
      return 0;
    end
    if (face_phase == mvwft_pkg::CIF_NONE) return 0;
    if (face_phase == mvwft_pkg::CIF_FIRST) begin
      fan_prev = c;
      face_phase = mvwft_pkg::CIF_SECOND;
      return 0;
    end
    face_phase = mvwft_pkg::CIF_FAN;
    if (first_ok && pos_usable(fan_prev.pos) && pos_usable(c.pos)) begin
      pending_words = {pending_words, weld_corner(fan_first, 1'b0)};
      pending_words = {pending_words, weld_corner(fan_prev, 1'b0)};
      pending_words = {pending_words, weld_corner(c, 1'b1)};
      fan_prev = c;
      return 3;
    end
    fan_prev = c;
    return 0;
  endfunction

  // Drives one corner, waits for acceptance and predicts its words.
  task automatic send_corner(input logic run, input logic face, input corner_t c,
                             output int n_words);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {c.nrm, c.tex, c.pos};
    s_tuser = {face, run};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    n_words = fan_corner(run, face, c);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Writes position_count over the configuration port.
  task automatic write_pos_count(input logic [16:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(4 * mvwft_pkg::REG_POSITION_COUNT);
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    pos_count = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Lets every expected word drain and the block return to idle.
  task automatic drain;
    while (pending_words.size() != 0 || !s_tready) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_index(int unsigned span);
    unique case ($urandom_range(19))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return span;
      default: return $urandom_range(span - 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_attr();
    unique case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(3);
    endcase
  endfunction

  // Random faces with short fans, run starts now and then, some noise.
  task automatic random_corners(input int n_items, input int unsigned span);
    int      left, len, n;
    corner_t c;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(19) == 0) begin
        c = {$urandom(), $urandom(), $urandom()};
        send_corner($urandom_range(1), $urandom_range(1), c, n);
        left--;
      end else begin
        len = $urandom_range(6, 3);
        for (int k = 0; k < len && left > 0; k++) begin
          c = {rand_index(span), rand_attr(), rand_attr()};
          send_corner(k == 0 && $urandom_range(7) == 0, k == 0, c, n);
          left--;
        end
      end
      if (left == n_items / 2 && $urandom_range(1)) drain();
    end
  endtask

  // Receiver stalls when asked to.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Checks each accepted vertex word against the oldest prediction.
  always @(posedge clk) begin
    vertex_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.vertex_index = m_tdata[15:0];
      got.source_position = m_tdata[31:16];
      got.source_texcoord = m_tdata[63:32];
      got.source_normal = m_tdata[95:64];
      got.is_new = m_tuser[0];
      got.uv_seen = m_tuser[1];
      got.normal_seen = m_tuser[2];
      got.overflow = m_tuser[3];
      got.triangle_last = m_tlast;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got.vertex_index !== want.vertex_index ||
            got.is_new !== want.is_new ||
            got.source_position !== want.source_position ||
            got.source_texcoord !== want.source_texcoord ||
            got.source_normal !== want.source_normal ||
            got.uv_seen !== want.uv_seen ||
            got.normal_seen !== want.normal_seen ||
            got.triangle_last !== want.triangle_last ||
            got.overflow !== want.overflow) begin
          $display("%0t: word mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #300_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Main sequence.
  initial begin
    row_t        rows[$];
    int          n;
    vertex_word_t last_word;
    rows = '{
      '{1, 1, '{0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 0, 0},
      '{0, 0, '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 0, 0},
      '{0, 0, '{2, 0, 0}, 3, 2, 1},
      '{0, 0, '{3, 0, 0}, 3, 3, 1},
      '{0, 0, '{4, 0, 0}, 0, 0, 0},
      '{0, 0, '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 0, 0},
      '{0, 0, '{2, 0, 0}, 3, 2, 0},
      '{0, 1, '{7, 1, 1}, 0, 0, 0},
      '{0, 0, '{0, 1, 1}, 0, 0, 0},
      '{0, 0, '{1, 1, 1}, 0, 0, 0},
      '{1, 0, '{0, 0, 0}, 0, 0, 0},
      '{0, 0, '{1, 0, 0}, 0, 0, 0},
      '{1, 1, '{3, 32'h7FFF_FFFF, 32'h8000_0000}, 0, 0, 0},
      '{0, 0, '{2, 0, 0}, 0, 0, 0},
      '{0, 0, '{1, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 3, 2, 1},
      '{0, 0, '{32'h8000_0000, 5, 5}, 0, 0, 0},
      '{0, 0, '{0, 5, 5}, 0, 0, 0},
      '{0, 0, '{3, 32'h7FFF_FFFF, 32'h8000_0000}, -1, 0, 0},
      '{0, 1, '{32'hFFFF_FFFF, 2, 2}, 0, 0, 0},
      '{0, 0, '{0, 2, 2}, 0, 0, 0},
      '{0, 0, '{1, 2, 2}, 0, 0, 0}
    };
    bucket_head.delete();
    vertex_count = 0;
    fan_first = '0;
    fan_prev = '0;
    face_phase = mvwft_pkg::CIF_NONE;
    first_ok = 1'b0;
    uv_flag = 1'b0;
    normal_flag = 1'b0;
    pos_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table with four usable positions.
    write_pos_count(17'd4);
    foreach (rows[i]) begin
      send_corner(rows[i].run, rows[i].face, rows[i].c, n);
      if (rows[i].n_words >= 0) begin
        if (n != rows[i].n_words) begin
          $display("%0t: row %0d word count, expected %0d, actual %0d",
                   $time, i, rows[i].n_words, n);
          errors++;
        end else if (n == 3) begin
          last_word = pending_words[pending_words.size()-1];
          if (last_word.vertex_index != rows[i].last_index ||
              last_word.is_new != rows[i].last_new) begin
            $display("%0t: row %0d, expected index %0d new %0b, actual %0d new %0b",
                     $time, i, rows[i].last_index, rows[i].last_new,
                     last_word.vertex_index, last_word.is_new);
            errors++;
          end
        end
      end
    end
    drain();

    // Random phases under different settings and idling patterns.
    write_pos_count(17'h1FFFF);
    random_corners(30, 16);
    drain();
    sender_idle_pct = 66;
    write_pos_count(17'd5);
    random_corners(25, 6);
    drain();
    sender_idle_pct = 0;
    receiver_stall_pct = 66;
    write_pos_count(17'd0);
    random_corners(8, 4);
    drain();
    write_pos_count(17'd65536);
    random_corners(20, 12);
    drain();
    sender_idle_pct = 24;
    receiver_stall_pct = 24;
    write_pos_count(17'd12);
    random_corners(20, 14);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mvwft_pkg.sv
hw/rtl/mvwft_bucket_mem.sv
hw/rtl/mvwft_vertex_mem.sv
hw/rtl/mesh_vertex_weld_fan_triangulate.sv
test/tb_mesh_vertex_weld_fan_triangulate.sv
